### rtl/rmsp_pkg.sv
// Shared codes and constants for the RMSprop parameter update core.
`timescale 1ns / 1ps

package rmsp_pkg;

    // item kinds (kind 3 behaves as a read)
    localparam logic [1:0] KIND_APPLY = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_L1_WEIGHT     = 1'b1;

    localparam logic [15:0] LR_RESET = 16'd66;
    localparam logic [15:0] L1_RESET = 16'd0;

    // decay coefficients in Q0.16
    localparam logic [15:0] COEF_OLD = 16'd62259;
    localparam logic [11:0] COEF_NEW = 12'd3277;

    localparam logic [47:0] MS_ONE = 48'h0001_0000_0000;

    // |p| > 100.0 in Q16.16
    localparam logic signed [31:0] EXPLODE_LIMIT = 32'sd6553600;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 48;

endpackage

### rtl/rmsprop_param_update_core.sv
// RMSprop parameter table with L1 shrink: memory-based pipelined update core.
`timescale 1ns / 1ps

// channel | dir | payload
// s_*     | in  | tdata: index[7:0], value[39:8]; tuser: kind[1:0]
// m_*     | out | tdata: param_value[31:0]; tuser: exploded[0]
// cfg_*   | in  | cfg_addr: register index; cfg_data: 16-bit value
//
// One word per cycle is taken unless a hazard, the clearing pass or an output
// stall holds it back; each word passes the 24-step root pipeline and the
// 48-step quotient pipeline before its result reaches the output register.
// A word addressing an entry still in flight waits until that entry leaves
// the pipeline, which any output stall delays further, since the state lives
// in the two memories. After reset a clearing pass writes each of the
// NUM_PARAMS entries of both memories; no word is taken during it. A held
// result stalls the pipeline only when the last stage holds a word.

module rmsprop_param_update_core
    import rmsp_pkg::*;
#(
    parameter int NUM_PARAMS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // index[7:0], value[39:8]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // param_value[31:0]
    output logic [0:0]  m_tuser     // exploded[0]
);

    localparam int AW    = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int NST   = 4 + SQRT_STEPS + DIV_STEPS + 2;
    localparam int SQ0   = 4;
    localparam int DV0   = SQ0 + SQRT_STEPS;
    localparam int U1    = DV0 + DIV_STEPS;
    localparam int U2    = U1 + 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  idx;
        logic        inr;
        logic        neg;
        logic [31:0] val;
        logic [31:0] p;
    } ctl_t;

    // configuration
    logic [15:0] lr_reg;
    logic [15:0] l1_reg;
    logic [31:0] k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= LR_RESET;
            l1_reg <= L1_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr[0])
                REG_LEARNING_RATE: lr_reg <= cfg_data;
                REG_L1_WEIGHT:     l1_reg <= cfg_data;
                default:           lr_reg <= lr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= lr_reg * l1_reg;
    end

    // clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(NUM_PARAMS - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // pipeline control
    logic        vld_reg [NST];
    ctl_t        ctl_reg [NST];
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_expl_reg;
    logic        out_free;
    logic        adv;
    logic        hazard;
    ctl_t        ctl_in;
    ctl_t        ctl_rd;

    assign out_free = !out_valid_reg || m_tready;
    assign adv      = out_free || !vld_reg[NST-1];

    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < NST; i++)
            if (vld_reg[i] && ctl_reg[i].idx == s_tdata[7:0])
                hazard = 1'b1;
    end

    assign s_tready = adv && !clr_active_reg && !hazard;

    always_comb
    begin
        ctl_in.kind = s_tuser;
        ctl_in.idx  = s_tdata[7:0];
        ctl_in.inr  = (s_tdata[7:0] < NUM_PARAMS);
        ctl_in.neg  = s_tdata[39];
        ctl_in.val  = s_tdata[39:8];
        ctl_in.p    = '0;
    end

    // memories
    logic [31:0] param_mem [NUM_PARAMS];
    logic [47:0] ms_mem    [NUM_PARAMS];
    logic [31:0] prd_reg;
    logic [47:0] msrd_reg;
    logic [47:0] ms_new;
    logic [31:0] p_final;
    logic        ms_we;
    logic        p_we;
    logic [31:0] p_wdata;

    // stage 1 picks up the parameter read for its word
    always_comb
    begin
        ctl_rd   = ctl_reg[0];
        ctl_rd.p = prd_reg;
    end

    assign ms_we = adv && vld_reg[2] && ctl_reg[2].kind == KIND_APPLY && ctl_reg[2].inr;
    assign p_we  = out_free && vld_reg[NST-1] && ctl_reg[NST-1].inr
                   && (ctl_reg[NST-1].kind == KIND_APPLY || ctl_reg[NST-1].kind == KIND_LOAD);
    assign p_wdata = (ctl_reg[NST-1].kind == KIND_APPLY) ? p_final : ctl_reg[NST-1].val;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prd_reg  <= param_mem[AW'(s_tdata[7:0])];
            msrd_reg <= ms_mem[AW'(s_tdata[7:0])];
        end
        priority if (clr_active_reg)
            param_mem[clr_cnt_reg] <= '0;
        else if (p_we)
            param_mem[AW'(ctl_reg[NST-1].idx)] <= p_wdata;
        priority if (clr_active_reg)
            ms_mem[clr_cnt_reg] <= MS_ONE;
        else if (ms_we)
            ms_mem[AW'(ctl_reg[2].idx)] <= ms_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid && s_tready;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_in;
            ctl_reg[1] <= ctl_rd;
            for (int i = 2; i < NST; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    // front arithmetic
    logic [31:0] mag2_reg;
    logic [47:0] ms2_reg;
    logic [63:0] g2_reg;
    logic [63:0] a3_reg;
    logic [47:0] num3_reg;
    logic [47:0] ms4_reg;
    logic [47:0] num4_reg;
    logic [75:0] b_prod;
    logic [77:0] ms_sum;

    assign b_prod = COEF_NEW * g2_reg;
    assign ms_sum = 78'(a3_reg) + 78'(b_prod) + 78'd32768;
    assign ms_new = (|ms_sum[77:64]) ? '1 : ms_sum[63:16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag2_reg <= ctl_reg[0].val[31] ? 32'(-ctl_reg[0].val) : ctl_reg[0].val;
            ms2_reg  <= msrd_reg;
            g2_reg   <= mag2_reg * mag2_reg;
            a3_reg   <= COEF_OLD * ms2_reg;
            num3_reg <= lr_reg * mag2_reg;
            ms4_reg  <= ms_new;
            num4_reg <= num3_reg;
        end
    end

    // integer root, one result bit per stage
    logic [47:0] sq_v   [SQRT_STEPS];
    logic [47:0] sq_r   [SQRT_STEPS];
    logic [47:0] sq_num [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [47:0] BIT = 48'd1 << (46 - 2 * j);
        logic [47:0] vin;
        logic [47:0] rin;
        logic [47:0] nin;
        logic [47:0] trial;

        if (j == 0)
        begin : g_first
            assign vin = ms4_reg;
            assign rin = '0;
            assign nin = num4_reg;
        end
        else
        begin : g_next
            assign vin = sq_v[j-1];
            assign rin = sq_r[j-1];
            assign nin = sq_num[j-1];
        end

        assign trial = rin + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_num[j] <= nin;
                if (vin >= trial)
                begin
                    sq_v[j] <= vin - trial;
                    sq_r[j] <= (rin >> 1) + BIT;
                end
                else
                begin
                    sq_v[j] <= vin;
                    sq_r[j] <= rin >> 1;
                end
            end
        end
    end

    // restoring divide, one quotient bit per stage
    logic [24:0] dv_rem [DIV_STEPS];
    logic [47:0] dv_q   [DIV_STEPS];
    logic [47:0] dv_num [DIV_STEPS];
    logic [24:0] dv_d   [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [24:0] rin;
        logic [47:0] qin;
        logic [47:0] nin;
        logic [24:0] din;
        logic [25:0] trial;

        if (j == 0)
        begin : g_first
            assign rin = '0;
            assign qin = '0;
            assign nin = sq_num[SQRT_STEPS-1];
            assign din = {1'b0, sq_r[SQRT_STEPS-1][23:0]} + 25'd1;
        end
        else
        begin : g_next
            assign rin = dv_rem[j-1];
            assign qin = dv_q[j-1];
            assign nin = dv_num[j-1];
            assign din = dv_d[j-1];
        end

        assign trial = {rin, nin[47]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_num[j] <= nin << 1;
                dv_d[j]   <= din;
                if (trial >= {1'b0, din})
                begin
                    dv_rem[j] <= 25'(trial - {1'b0, din});
                    dv_q[j]   <= {qin[46:0], 1'b1};
                end
                else
                begin
                    dv_rem[j] <= rin[24:0] << 1 | 25'(nin[47]);
                    dv_q[j]   <= {qin[46:0], 1'b0};
                end
            end
        end
    end

    // step, saturate, shrink
    logic signed [49:0] p_ext;
    logic signed [49:0] q_ext;
    logic signed [49:0] p_step;
    logic [31:0]        pn_sat;
    logic [31:0]        pn1_reg;
    logic [31:0]        pn2_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        pm;
    logic [31:0]        shrink;

    assign p_ext  = 50'(signed'(ctl_reg[U1-1].p));
    assign q_ext  = signed'({2'b00, dv_q[DIV_STEPS-1]});
    assign p_step = ctl_reg[U1-1].neg ? p_ext + q_ext : p_ext - q_ext;

    always_comb
    begin
        priority if (p_step > 50'sd2147483647)
            pn_sat = 32'h7FFF_FFFF;
        else if (p_step < -50'sd2147483648)
            pn_sat = 32'h8000_0000;
        else
            pn_sat = p_step[31:0];
    end

    assign pm     = pn1_reg[31] ? 32'(-pn1_reg) : pn1_reg;
    assign shrink = prod_reg[63:32];
    assign p_final = pn2_reg[31] ? pn2_reg + shrink : pn2_reg - shrink;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pn1_reg  <= pn_sat;
            pn2_reg  <= pn1_reg;
            prod_reg <= pm * k_reg;
        end
    end

    // result
    logic [31:0] res_val;

    always_comb
    begin
        if (!ctl_reg[NST-1].inr)
            res_val = '0;
        else if (ctl_reg[NST-1].kind == KIND_APPLY)
            res_val = p_final;
        else if (ctl_reg[NST-1].kind == KIND_LOAD)
            res_val = ctl_reg[NST-1].val;
        else
            res_val = ctl_reg[NST-1].p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= vld_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= res_val;
            out_expl_reg <= (signed'(res_val) > EXPLODE_LIMIT)
                            || (signed'(res_val) < -EXPLODE_LIMIT);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_expl_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("word taken during clearing pass");

    a_clear_length: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_cnt_reg) == AW'(NUM_PARAMS - 1))
        else $error("clearing pass ended early");

    a_explode_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] == ((signed'(m_tdata) > EXPLODE_LIMIT)
                                    || (signed'(m_tdata) < -EXPLODE_LIMIT)))
        else $error("exploded flag does not match value");
`endif

endmodule
